// ===== rtl/envl_pkg.sv =====
// Shared types and constants for the attack-decay envelope generator with VCA.
// Used by envl_front, envl_back and ad_envelope_with_loop_and_vca_unit.
// No dependencies.
package envl_pkg;

   // voices and curve table size
   localparam int CHANNELS    = 16;
   localparam int CURVE_DEPTH = 1024;
   localparam int VOICE_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int IDX_W       = $clog2(CURVE_DEPTH);
   localparam int TAB_ADDR_W  = IDX_W + 1;

   // fixed-point constants
   localparam logic [16:0] ONE_Q16  = 17'h10000;
   localparam logic [16:0] HALF_Q16 = 17'h08000;
   localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
   localparam logic signed [14:0] TRIG_MV   = 15'sd1000;
   localparam logic signed [14:0] VCA_MAX   = 15'sd10000;
   localparam logic [13:0]        ENV_MV_FS = 14'd10000;

   // stage codes
   localparam logic [1:0] ST_STOP    = 2'd0;
   localparam logic [1:0] ST_ATTACK  = 2'd1;
   localparam logic [1:0] ST_DECAY   = 2'd2;
   localparam logic [1:0] ST_RELEASE = 2'd3;

   // register indexes
   localparam logic [2:0] REG_LOOP_MODE     = 3'd0;
   localparam logic [2:0] REG_CURVE_SHAPE   = 3'd1;
   localparam logic [2:0] REG_OUTPUT_LEVEL  = 3'd2;
   localparam logic [2:0] REG_LEVEL_TO_ENV  = 3'd3;
   localparam logic [2:0] REG_ATTACK_TICKS  = 3'd4;
   localparam logic [2:0] REG_DECAY_TICKS   = 3'd5;
   localparam logic [2:0] REG_SHORTEST      = 3'd6;
   localparam logic [2:0] REG_CHANNEL_COUNT = 3'd7;

   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_TABLE = 1'b1
   } op_type;

   typedef struct packed {
      logic        loop_on;
      logic [16:0] curve_shape;
      logic [16:0] output_level;
      logic        level_to_envelope;
      logic [19:0] attack_ticks;
      logic [19:0] decay_ticks;
      logic [19:0] shortest_ticks;
      logic [4:0]  trigger_channel_count;
   } envl_cfg_type;

   // one classified request as it waits in the queue
   typedef struct packed {
      op_type               op;
      logic                 advance;
      logic [VOICE_W-1:0]   voice;
      logic [3:0]           channel;
      logic signed [14:0]   trigger_mv;
      logic signed [20:0]   attack_offset;
      logic signed [20:0]   decay_offset;
      logic signed [14:0]   audio_mv;
      logic                 curve_select;
      logic [9:0]           curve_index;
      logic [16:0]          curve_value;
   } envl_item_type;

endpackage

// ===== rtl/envl_front.sv =====
// Front end: accepts requests, classifies them by voice, drops ticks for
// channels past a voice count above one; holds them in a 2-entry queue.
// Depends on envl_pkg.
module envl_front (
   input  logic                    clock,
   input  logic                    reset,
   input  envl_pkg::envl_cfg_type  cfg,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // channel, trigger_mv, attack_offset, decay_offset, audio_mv,
   // curve_select, curve_index, curve_value
   input  logic [103:0]            req_tdata,
   // kind
   input  logic                    req_tuser,
   output logic                    q_valid,
   output envl_pkg::envl_item_type q_item,
   input  logic                    q_pop
);
   import envl_pkg::*;

   envl_item_type entry_ff [2];
   logic          wr_ptr_ff, rd_ptr_ff;
   logic [1:0]    fill_ff;
   logic [4:0]    count_eff;
   logic          shared;
   logic          drop;
   logic          push;
   envl_item_type item;

   // effective voice count
   always_comb begin
      count_eff = cfg.trigger_channel_count;
      if (count_eff == 5'd0) count_eff = 5'd1;
      if (count_eff > 5'(CHANNELS)) count_eff = 5'(CHANNELS);
   end

   // classify
   always_comb begin
      shared             = (count_eff == 5'd1);
      item.op            = req_tuser ? OP_TABLE : OP_TICK;
      item.channel       = req_tdata[3:0];
      item.trigger_mv    = $signed(req_tdata[18:4]);
      item.attack_offset = $signed(req_tdata[39:19]);
      item.decay_offset  = $signed(req_tdata[60:40]);
      item.audio_mv      = $signed(req_tdata[75:61]);
      item.curve_select  = req_tdata[76];
      item.curve_index   = req_tdata[86:77];
      item.curve_value   = req_tdata[103:87];
      item.voice         = shared ? '0 : req_tdata[VOICE_W-1:0];
      item.advance       = shared ? (req_tdata[3:0] == 4'd0) : 1'b1;
      drop = !req_tuser && !shared && ({1'b0, req_tdata[3:0]} >= count_eff);
   end

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready && !drop;
   assign q_valid    = (fill_ff != 2'd0);
   assign q_item     = entry_ff[rd_ptr_ff];

   // queue storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= item;
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (q_pop) rd_ptr_ff <= !rd_ptr_ff;
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, q_pop};
      end
   end

endmodule

// ===== rtl/envl_back.sv =====
// Back end: per-voice envelope state, serial divider for stage steps,
// curve table memory, curve blend, VCA and the result register.
// Depends on envl_pkg.
module envl_back (
   input  logic                    clock,
   input  logic                    reset,
   input  envl_pkg::envl_cfg_type  cfg,
   input  logic                    q_valid,
   input  envl_pkg::envl_item_type q_item,
   output logic                    q_pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // out_channel, envelope_mv, vca_mv, stage_now, zero fill
   output logic [39:0]             rsp_tdata
);
   import envl_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_TRIG, S_MUL, S_DIV, S_STEP, S_IDX, S_BL1, S_BL2, S_BL3,
      S_ENV1, S_ENV2, S_OUT1, S_OUT2, S_OUT3, S_OUT4, S_RESULT
   } state_type;

   localparam logic [5:0] DIV_LAST = 6'd48;

   // per-voice state
   logic [1:0]  stage_ff [CHANNELS];
   logic [32:0] lvl_ff   [CHANNELS];
   logic [16:0] base_ff  [CHANNELS];
   logic [16:0] span_ff  [CHANNELS];
   logic [16:0] slope_ff [CHANNELS];
   logic [16:0] env_ff   [CHANNELS];
   logic        high_ff  [CHANNELS];

   // curve table
   logic [16:0] curve_mem [2*CURVE_DEPTH];
   logic [16:0] tab_ff;

   state_type     state_ff;
   envl_item_type item_ff;
   logic [1:0]    w_stage_ff;
   logic [32:0]   w_lvl_ff;
   logic [16:0]   w_base_ff, w_span_ff, w_slope_ff, w_env_ff;
   logic          att_ff;
   logic [20:0]   t_ff;
   logic [37:0]   div_d_ff, rem_ff;
   logic [48:0]   quo_ff;
   logic [5:0]    cnt_ff;
   logic [33:0]   p1_ff, p2_ff, q2_ff, ea_ff;
   logic [16:0]   r_ff, m1_ff;
   logic [31:0]   xa_ff;
   logic [13:0]   emv_ff;
   logic [14:0]   vca_ff;
   logic          rsp_valid_ff;
   logic [39:0]   rsp_data_ff;

   logic [VOICE_W-1:0] v;
   assign v = item_ff.voice;

   // trigger edge handling on the voice being ticked
   logic        trig_high, edge_hit;
   logic [1:0]  tr_stage;
   logic [32:0] tr_lvl;
   logic [16:0] tr_base, tr_span, tr_slope, env_v;
   always_comb begin
      env_v     = env_ff[v];
      tr_stage  = stage_ff[v];
      tr_lvl    = lvl_ff[v];
      tr_base   = base_ff[v];
      tr_span   = span_ff[v];
      tr_slope  = slope_ff[v];
      trig_high = (item_ff.trigger_mv >= TRIG_MV);
      edge_hit  = item_ff.advance && trig_high && !high_ff[v];
      if (edge_hit) begin
         if (stage_ff[v] == ST_STOP) begin
            tr_stage = ST_ATTACK; tr_lvl = '0; tr_base = '0;
            tr_span  = ONE_Q16;   tr_slope = ONE_Q16;
         end else if (stage_ff[v] == ST_RELEASE || (!cfg.loop_on &&
                      stage_ff[v] == ST_DECAY)) begin
            tr_stage = ST_ATTACK; tr_lvl = '0; tr_base = env_v;
            tr_span  = ONE_Q16 - env_v; tr_slope = ONE_Q16 - env_v;
         end else if (cfg.loop_on) begin
            tr_stage = ST_RELEASE; tr_lvl = ONE_Q32; tr_base = '0;
            tr_span  = env_v;
         end
      end
   end

   // attack on a moving voice with no slope left finishes at once
   logic zero_slope;
   assign zero_slope = (item_ff.op == OP_TICK) && item_ff.advance &&
                       (tr_stage == ST_ATTACK) && (tr_slope == 17'd0);

   // stage duration with lower clamp
   logic [19:0]        lo_ticks, use_ticks;
   logic signed [20:0] use_off;
   logic signed [22:0] t_sum;
   logic [20:0]        t_clamp;
   always_comb begin
      lo_ticks  = (cfg.shortest_ticks == 20'd0) ? 20'd1 : cfg.shortest_ticks;
      use_ticks = (tr_stage == ST_ATTACK) ? cfg.attack_ticks : cfg.decay_ticks;
      use_off   = (tr_stage == ST_ATTACK) ? item_ff.attack_offset
                                          : item_ff.decay_offset;
      t_sum     = $signed({3'b000, use_ticks}) + 23'(use_off);
      t_clamp   = (t_sum < $signed({3'b000, lo_ticks})) ? {1'b0, lo_ticks}
                                                        : t_sum[20:0];
   end

   // restoring divider step: 2^48 / divisor, one quotient bit per cycle
   logic [38:0] rem_sh, rem_sub;
   logic        div_ge;
   always_comb begin
      rem_sh  = {rem_ff, (cnt_ff == DIV_LAST)};
      div_ge  = (rem_sh >= {1'b0, div_d_ff});
      rem_sub = rem_sh - {1'b0, div_d_ff};
   end

   // attack accumulation
   logic [49:0] att_sum;
   assign att_sum = 50'(w_lvl_ff) + 50'(quo_ff);

   // curve blend selection
   logic [16:0] shape_sat, lvl_sat, w_blend, v16, blend_a, blend_b;
   logic [15:0] shape_hi;
   logic        shape_lo, tab_sel;
   logic [32+IDX_W:0] idx_prod;
   logic [IDX_W-1:0]  rd_idx;
   always_comb begin
      shape_sat = (cfg.curve_shape > ONE_Q16) ? ONE_Q16 : cfg.curve_shape;
      lvl_sat   = (cfg.output_level > ONE_Q16) ? ONE_Q16 : cfg.output_level;
      shape_lo  = (shape_sat < HALF_Q16);
      shape_hi  = 16'(shape_sat - HALF_Q16);
      w_blend   = shape_lo ? {shape_sat[15:0], 1'b0} : {shape_hi, 1'b0};
      tab_sel   = att_ff ? !shape_lo : shape_lo;
      v16       = w_lvl_ff[32:16];
      blend_a   = shape_lo ? tab_ff : v16;
      blend_b   = shape_lo ? v16 : tab_ff;
      idx_prod  = (IDX_W+33)'(w_lvl_ff) * (IDX_W+33)'(CURVE_DEPTH - 1);
      rd_idx    = idx_prod[IDX_W+31:32];
   end

   // envelope from blend
   logic [18:0] env_sum;
   logic [16:0] env_new;
   always_comb begin
      env_sum = {2'b00, w_base_ff} + {1'b0, q2_ff[33:16]};
      env_new = (env_sum > 19'(ONE_Q16)) ? ONE_Q16 : env_sum[16:0];
   end

   // VCA magnitude
   logic [14:0] mag;
   logic [30:0] emv_prod;
   logic [48:0] vca_prod;
   logic [14:0] vca_mag;
   always_comb begin
      mag      = item_ff.audio_mv[14] ? 15'(-item_ff.audio_mv)
                                      : 15'(item_ff.audio_mv);
      emv_prod = 31'(m1_ff) * 31'(ENV_MV_FS);
      vca_prod = 49'(xa_ff) * 49'(lvl_sat);
      vca_mag  = (vca_prod[48:32] > 17'(VCA_MAX)) ? 15'(VCA_MAX)
                                                  : vca_prod[46:32];
   end

   // memory port controls
   logic                  mem_we;
   logic [TAB_ADDR_W-1:0] mem_waddr;
   logic [16:0]           mem_wval;
   assign mem_we    = (state_ff == S_TRIG) && (item_ff.op == OP_TABLE) &&
                      (32'(item_ff.curve_index) < CURVE_DEPTH);
   assign mem_waddr = {item_ff.curve_select, IDX_W'(item_ff.curve_index)};
   assign mem_wval  = (item_ff.curve_value > ONE_Q16) ? ONE_Q16
                                                      : item_ff.curve_value;

   always_ff @(posedge clock) begin
      if (mem_we) curve_mem[mem_waddr] <= mem_wval;
      if (state_ff == S_IDX) tab_ff <= curve_mem[{tab_sel, rd_idx}];
   end

   // voice state writeback
   logic hi_we, wb_we;
   assign hi_we = (state_ff == S_TRIG) && (item_ff.op == OP_TICK) && item_ff.advance;
   assign wb_we = (state_ff == S_ENV2);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            stage_ff[i] <= ST_STOP;
            lvl_ff[i]   <= '0;
            base_ff[i]  <= '0;
            span_ff[i]  <= ONE_Q16;
            slope_ff[i] <= ONE_Q16;
            env_ff[i]   <= '0;
            high_ff[i]  <= 1'b0;
         end
      end else begin
         if (hi_we) high_ff[v] <= trig_high;
         if (wb_we) begin
            stage_ff[v] <= w_stage_ff;
            lvl_ff[v]   <= w_lvl_ff;
            base_ff[v]  <= w_base_ff;
            span_ff[v]  <= w_span_ff;
            slope_ff[v] <= w_slope_ff;
            env_ff[v]   <= env_new;
         end
      end
   end

   assign q_pop      = (state_ff == S_IDLE) && q_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != S_RESULT)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  item_ff  <= q_item;
                  state_ff <= S_TRIG;
               end
            end
            S_TRIG: begin
               w_slope_ff <= tr_slope;
               w_env_ff   <= env_v;
               t_ff       <= t_clamp;
               att_ff     <= (tr_stage == ST_ATTACK);
               if (zero_slope) begin
                  w_stage_ff <= ST_DECAY;
                  w_lvl_ff   <= ONE_Q32;
                  w_base_ff  <= '0;
                  w_span_ff  <= ONE_Q16;
               end else begin
                  w_stage_ff <= tr_stage;
                  w_lvl_ff   <= tr_lvl;
                  w_base_ff  <= tr_base;
                  w_span_ff  <= tr_span;
               end
               if (item_ff.op == OP_TABLE) begin
                  state_ff <= S_IDLE;
               end else if (!item_ff.advance || tr_stage == ST_STOP) begin
                  state_ff <= S_OUT1;
               end else if (zero_slope) begin
                  state_ff <= S_IDX;
               end else begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               div_d_ff <= 38'(t_ff) * 38'(att_ff ? w_slope_ff : ONE_Q16);
               rem_ff   <= '0;
               cnt_ff   <= DIV_LAST;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               rem_ff <= div_ge ? rem_sub[37:0] : rem_sh[37:0];
               quo_ff <= {quo_ff[47:0], div_ge};
               cnt_ff <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd0) state_ff <= S_STEP;
            end
            S_STEP: begin
               if (att_ff) begin
                  if (att_sum >= 50'(ONE_Q32)) begin
                     w_stage_ff <= ST_DECAY;
                     w_lvl_ff   <= ONE_Q32;
                     w_base_ff  <= '0;
                     w_span_ff  <= ONE_Q16;
                  end else begin
                     w_lvl_ff <= att_sum[32:0];
                  end
               end else if (quo_ff < 49'(w_lvl_ff)) begin
                  w_lvl_ff <= w_lvl_ff - quo_ff[32:0];
               end else if (w_stage_ff == ST_RELEASE) begin
                  w_stage_ff <= ST_STOP;
                  w_lvl_ff   <= '0;
                  w_base_ff  <= '0;
                  w_span_ff  <= ONE_Q16;
               end else if (cfg.loop_on) begin
                  w_stage_ff <= ST_ATTACK;
                  w_lvl_ff   <= '0;
                  w_base_ff  <= '0;
                  w_span_ff  <= ONE_Q16;
                  w_slope_ff <= ONE_Q16;
               end else begin
                  w_stage_ff <= ST_STOP;
                  w_lvl_ff   <= '0;
                  w_base_ff  <= '0;
                  w_span_ff  <= '0;
               end
               state_ff <= S_IDX;
            end
            S_IDX: state_ff <= S_BL1;
            S_BL1: begin
               p1_ff    <= 34'(blend_a) * 34'(ONE_Q16 - w_blend);
               state_ff <= S_BL2;
            end
            S_BL2: begin
               p2_ff    <= 34'(blend_b) * 34'(w_blend);
               state_ff <= S_BL3;
            end
            S_BL3: begin
               r_ff     <= 17'(({1'b0, p1_ff} + {1'b0, p2_ff}) >> 16);
               state_ff <= S_ENV1;
            end
            S_ENV1: begin
               q2_ff    <= 34'(r_ff) * 34'(w_span_ff);
               state_ff <= S_ENV2;
            end
            S_ENV2: begin
               w_env_ff <= env_new;
               state_ff <= S_OUT1;
            end
            S_OUT1: begin
               ea_ff    <= 34'(w_env_ff) * 34'(lvl_sat);
               state_ff <= S_OUT2;
            end
            S_OUT2: begin
               xa_ff    <= 32'(mag) * 32'(w_env_ff);
               m1_ff    <= cfg.level_to_envelope ? ea_ff[32:16] : w_env_ff;
               state_ff <= S_OUT3;
            end
            S_OUT3: begin
               emv_ff   <= emv_prod[29:16];
               state_ff <= S_OUT4;
            end
            S_OUT4: begin
               vca_ff   <= item_ff.audio_mv[14] ? 15'(-vca_mag) : vca_mag;
               state_ff <= S_RESULT;
            end
            S_RESULT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {5'd0, w_stage_ff, vca_ff, emv_ff,
                                   item_ff.channel};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/ad_envelope_with_loop_and_vca_unit.sv =====
// Top level of the polyphonic attack-decay envelope generator with VCA:
// register file, front end with request queue, back end sequencer.
// Depends on envl_pkg, envl_front, envl_back.
//
//   port group | direction | handshake            | payload
//   req_*      | in        | tvalid/tready        | tdata 104 b, tuser kind
//   rsp_*      | out       | tvalid/tready        | tdata 40 b
//   csr_*      | in/out    | psel/penable, pready | 8 registers at 4*i
//
// An accepted request is held in the front-end queue until the back end takes
// it. The back end ends a table write in its trigger state, takes a tick that
// does not move its voice straight to the output states, and runs a moving tick
// through the one-bit-per-cycle divider unless its attack ends on a zero slope.
// Synchronous active-high reset returns all voices to stop; the curve table
// is not cleared. A two-entry queue keeps requests flowing while the back
// end works or a result waits in the output register.
module ad_envelope_with_loop_and_vca_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // channel[3:0], trigger_mv[18:4], attack_offset[39:19],
   // decay_offset[60:40], audio_mv[75:61], curve_select[76],
   // curve_index[86:77], curve_value[103:87]
   input  logic [103:0] req_tdata,
   // kind
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_channel[3:0], envelope_mv[17:4], vca_mv[32:18], stage_now[34:33]
   output logic [39:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import envl_pkg::*;

   envl_cfg_type  cfg_ff;
   envl_item_type q_item;
   logic          q_valid, q_pop;
   logic          csr_we;
   logic [2:0]    csr_idx;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[4:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.loop_on               <= 1'b0;
         cfg_ff.curve_shape           <= HALF_Q16;
         cfg_ff.output_level          <= ONE_Q16;
         cfg_ff.level_to_envelope     <= 1'b0;
         cfg_ff.attack_ticks          <= 20'd48;
         cfg_ff.decay_ticks           <= 20'd48;
         cfg_ff.shortest_ticks        <= 20'd48;
         cfg_ff.trigger_channel_count <= 5'd1;
      end else if (csr_we) begin
         unique case (csr_idx)
            REG_LOOP_MODE:     cfg_ff.loop_on               <= csr_pwdata[0];
            REG_CURVE_SHAPE:   cfg_ff.curve_shape           <= csr_pwdata[16:0];
            REG_OUTPUT_LEVEL:  cfg_ff.output_level          <= csr_pwdata[16:0];
            REG_LEVEL_TO_ENV:  cfg_ff.level_to_envelope     <= csr_pwdata[0];
            REG_ATTACK_TICKS:  cfg_ff.attack_ticks          <= csr_pwdata[19:0];
            REG_DECAY_TICKS:   cfg_ff.decay_ticks           <= csr_pwdata[19:0];
            REG_SHORTEST:      cfg_ff.shortest_ticks        <= csr_pwdata[19:0];
            REG_CHANNEL_COUNT: cfg_ff.trigger_channel_count <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (csr_idx)
         REG_LOOP_MODE:     csr_prdata = {31'd0, cfg_ff.loop_on};
         REG_CURVE_SHAPE:   csr_prdata = {15'd0, cfg_ff.curve_shape};
         REG_OUTPUT_LEVEL:  csr_prdata = {15'd0, cfg_ff.output_level};
         REG_LEVEL_TO_ENV:  csr_prdata = {31'd0, cfg_ff.level_to_envelope};
         REG_ATTACK_TICKS:  csr_prdata = {12'd0, cfg_ff.attack_ticks};
         REG_DECAY_TICKS:   csr_prdata = {12'd0, cfg_ff.decay_ticks};
         REG_SHORTEST:      csr_prdata = {12'd0, cfg_ff.shortest_ticks};
         REG_CHANNEL_COUNT: csr_prdata = {27'd0, cfg_ff.trigger_channel_count};
         default:           csr_prdata = 32'd0;
      endcase
   end

   envl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   envl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // back end never pops an empty queue
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("queue popped while empty");

   // envelope output stays within full scale
   a_env_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[17:4] <= ENV_MV_FS))
      else $error("envelope beyond full scale");

   // VCA output is clamped
   a_vca_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[32:18]) <= VCA_MAX &&
                      $signed(rsp_tdata[32:18]) >= -VCA_MAX))
      else $error("vca output not clamped");

endmodule

// ===== tb/envl_checker.sv =====
// Checker for the attack-decay envelope generator: watches the request, result
// and register channels, predicts every result and compares it field by field.
// Depends on envl_pkg.
`timescale 1ns / 1ps

module envl_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [103:0] req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [39:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic         csr_pready,
   output int           fail_count,
   output int           pending
);
   import envl_pkg::*;

   typedef struct {
      logic [3:0]         channel;
      logic [13:0]        env_mv;
      logic signed [14:0] vca_mv;
      logic [1:0]         stage;
   } envl_result_type;

   localparam longint unsigned FULL_Q32 = 64'h1_0000_0000;
   localparam longint unsigned UNIT_Q16 = 64'h1_0000;

   envl_result_type results_due[$];

   // register copy
   logic        cf_loop;
   logic [16:0] cf_shape;
   logic [16:0] cf_level;
   logic        cf_l2e;
   logic [19:0] cf_att;
   logic [19:0] cf_dec;
   logic [19:0] cf_short;
   logic [4:0]  cf_count;

   // voice state
   logic [1:0]        v_stage [CHANNELS];
   longint unsigned   v_level [CHANNELS];
   longint unsigned   v_base  [CHANNELS];
   longint unsigned   v_span  [CHANNELS];
   longint unsigned   v_slope [CHANNELS];
   longint unsigned   v_env   [CHANNELS];
   bit                v_high  [CHANNELS];
   longint unsigned   curve_tab [2*CURVE_DEPTH];

   function automatic longint unsigned stage_len(logic [19:0] ticks, longint off);
      longint lo;
      longint t;
      lo = (cf_short != 0) ? longint'(cf_short) : 1;
      t  = longint'(ticks) + off;
      return (t < lo) ? lo : t;
   endfunction

   // blend of table curve and linear ramp
   function automatic longint unsigned curve_at(longint unsigned lv, int first, int second);
      longint unsigned v16, idx, s, w, r;
      v16 = lv >> 16;
      idx = (lv * (CURVE_DEPTH - 1)) >> 32;
      s   = (cf_shape > UNIT_Q16) ? UNIT_Q16 : cf_shape;
      if (idx >= CURVE_DEPTH) idx = CURVE_DEPTH - 1;
      if (s < 32768) begin
         w = 2 * s;
         r = (curve_tab[first*CURVE_DEPTH + idx] * (UNIT_Q16 - w) + v16 * w) >> 16;
      end else begin
         w = 2 * (s - 32768);
         r = (v16 * (UNIT_Q16 - w) + curve_tab[second*CURVE_DEPTH + idx] * w) >> 16;
      end
      return r;
   endfunction

   function automatic longint unsigned env_from(int c, longint unsigned r);
      longint unsigned e;
      e = v_base[c] + ((r * v_span[c]) >> 16);
      return (e > UNIT_Q16) ? UNIT_Q16 : e;
   endfunction

   function automatic void attack_from_here(int c);
      v_stage[c] = ST_ATTACK;
      v_level[c] = 0;
      v_base[c]  = v_env[c];
      v_span[c]  = UNIT_Q16 - v_env[c];
      v_slope[c] = UNIT_Q16 - v_env[c];
   endfunction

   function automatic void attack_from_zero(int c);
      v_stage[c] = ST_ATTACK;
      v_level[c] = 0;
      v_base[c]  = 0;
      v_span[c]  = UNIT_Q16;
      v_slope[c] = UNIT_Q16;
   endfunction

   function automatic void step_voice(int c, longint trig, longint aoff, longint doff);
      bit high;
      bit done;
      longint unsigned t, step;
      high = (trig >= TRIG_MV);
      // edge handling
      if (high && !v_high[c]) begin
         if (v_stage[c] == ST_STOP) attack_from_zero(c);
         else if (v_stage[c] == ST_RELEASE) attack_from_here(c);
         else if (cf_loop) begin
            v_stage[c] = ST_RELEASE;
            v_level[c] = FULL_Q32;
            v_base[c]  = 0;
            v_span[c]  = v_env[c];
         end else if (v_stage[c] == ST_DECAY) attack_from_here(c);
      end
      v_high[c] = high;

      if (v_stage[c] == ST_ATTACK) begin
         t    = stage_len(cf_att, aoff);
         done = (v_slope[c] == 0);
         if (!done) begin
            v_level[c] += (64'd1 << 48) / (t * v_slope[c]);
            done = (v_level[c] >= FULL_Q32);
         end
         if (done) begin
            v_stage[c] = ST_DECAY;
            v_level[c] = FULL_Q32;
            v_base[c]  = 0;
            v_span[c]  = UNIT_Q16;
         end
         v_env[c] = env_from(c, curve_at(v_level[c], 0, 1));
      end else if (v_stage[c] == ST_DECAY || v_stage[c] == ST_RELEASE) begin
         step = FULL_Q32 / stage_len(cf_dec, doff);
         if (step < v_level[c]) v_level[c] -= step;
         else if (v_stage[c] == ST_RELEASE) begin
            v_stage[c] = ST_STOP;
            v_level[c] = 0;
            v_base[c]  = 0;
            v_span[c]  = UNIT_Q16;
         end else if (cf_loop) attack_from_zero(c);
         else begin
            v_stage[c] = ST_STOP;
            v_level[c] = 0;
            v_base[c]  = 0;
            v_span[c]  = 0;
         end
         v_env[c] = env_from(c, curve_at(v_level[c], 1, 0));
      end
   endfunction

   // work out the result of one accepted request, if any
   function automatic void predict_request(logic kind, logic [103:0] d);
      int              ch, count, v, tab_addr;
      longint          audio;
      longint unsigned gain, env, emv, mag;
      envl_result_type res;
      ch = d[3:0];
      if (kind == OP_TABLE) begin
         tab_addr = int'(d[76]) * CURVE_DEPTH + int'(d[86:77]);
         curve_tab[tab_addr] = (d[103:87] > ONE_Q16) ? UNIT_Q16 : d[103:87];
         return;
      end
      count = cf_count;
      if (count == 0) count = 1;
      if (count > CHANNELS) count = CHANNELS;
      if (count == 1) begin
         v = 0;
         if (ch == 0)
            step_voice(0, $signed(d[18:4]), $signed(d[39:19]), $signed(d[60:40]));
      end else begin
         if (ch >= count) return;
         v = ch;
         step_voice(v, $signed(d[18:4]), $signed(d[39:19]), $signed(d[60:40]));
      end
      gain = (cf_level > ONE_Q16) ? UNIT_Q16 : cf_level;
      env  = v_env[v];
      emv  = cf_l2e ? ((((env * gain) >> 16) * 10000) >> 16) : ((env * 10000) >> 16);
      audio = $signed(d[75:61]);
      mag  = (audio < 0) ? -audio : audio;
      mag  = (mag * env * gain) >> 32;
      if (mag > 10000) mag = 10000;
      res.channel = 4'(ch);
      res.env_mv  = emv[13:0];
      res.vca_mv  = (audio < 0) ? -15'(mag) : 15'(mag);
      res.stage   = v_stage[v];
      results_due.push_back(res);
   endfunction

   always @(posedge clock) begin
      envl_result_type want;
      if (reset) begin
         cf_loop  <= 1'b0;
         cf_shape <= 17'd32768;
         cf_level <= 17'd65536;
         cf_l2e   <= 1'b0;
         cf_att   <= 20'd48;
         cf_dec   <= 20'd48;
         cf_short <= 20'd48;
         cf_count <= 5'd1;
         for (int c = 0; c < CHANNELS; c++) begin
            v_stage[c] = ST_STOP;
            v_level[c] = 0;
            v_base[c]  = 0;
            v_span[c]  = UNIT_Q16;
            v_slope[c] = UNIT_Q16;
            v_env[c]   = 0;
            v_high[c]  = 0;
         end
         results_due.delete();
      end else begin
         // results first: one accepted now cannot stem from a request of this edge
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               $error("unexpected result: tdata %h", rsp_tdata);
               fail_count++;
            end else begin
               want = results_due.pop_front();
               if (rsp_tdata[3:0] !== want.channel) begin
                  $error("out_channel: expected %0d, got %0d", want.channel, rsp_tdata[3:0]);
                  fail_count++;
               end
               if (rsp_tdata[17:4] !== want.env_mv) begin
                  $error("envelope_mv: expected %0d, got %0d", want.env_mv, rsp_tdata[17:4]);
                  fail_count++;
               end
               if (rsp_tdata[32:18] !== want.vca_mv) begin
                  $error("vca_mv: expected %0d, got %0d", want.vca_mv,
                         $signed(rsp_tdata[32:18]));
                  fail_count++;
               end
               if (rsp_tdata[34:33] !== want.stage) begin
                  $error("stage_now: expected %0d, got %0d", want.stage, rsp_tdata[34:33]);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) predict_request(req_tuser, req_tdata);
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_LOOP_MODE:     cf_loop  <= csr_pwdata[0];
               REG_CURVE_SHAPE:   cf_shape <= csr_pwdata[16:0];
               REG_OUTPUT_LEVEL:  cf_level <= csr_pwdata[16:0];
               REG_LEVEL_TO_ENV:  cf_l2e   <= csr_pwdata[0];
               REG_ATTACK_TICKS:  cf_att   <= csr_pwdata[19:0];
               REG_DECAY_TICKS:   cf_dec   <= csr_pwdata[19:0];
               REG_SHORTEST:      cf_short <= csr_pwdata[19:0];
               REG_CHANNEL_COUNT: cf_count <= csr_pwdata[4:0];
               default: ;
            endcase
         end
      end
      pending = results_due.size();
   end

   initial begin
      fail_count = 0;
      pending    = 0;
   end

endmodule

// ===== tb/tb_top.sv =====
// Top of the envelope generator testbench: clock, reset, request and register
// stimulus, result back-pressure, watchdog and verdict.
// Depends on envl_pkg, envl_checker and the ad_envelope_with_loop_and_vca_unit RTL.
`timescale 1ns / 1ps

module tb_top;
   import envl_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int PHASE_REQS = 125;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [103:0] req_tdata;   // channel, trigger_mv, attack_offset, decay_offset,
                              // audio_mv, curve_select, curve_index, curve_value
   logic         req_tuser;   // kind
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [39:0]  rsp_tdata;   // out_channel, envelope_mv, vca_mv, stage_now
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [4:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   int  fail_count;
   int  pending;
   bit  steady;
   int  stall_left;
   int  idle_cycles;
   bit  trig_high [CHANNELS];

   // loop, shape, level, level_to_env, attack, decay, shortest, count
   int  cfg_sets [8][8] = '{
      '{0, 32768,  65536, 0,      48,      48, 48,  1},
      '{1, 32768,  65536, 0,      20,      30,  4, 16},
      '{0,     0,  40000, 1,      10,      60,  2, 16},
      '{1, 65536, 131071, 1,       1,       5,  0,  4},
      '{0, 20000,      0, 0,     200,     100,  1,  0},
      '{1, 50000,  65536, 1,      12,      12,  8, 31},
      '{0, 32768,  70000, 0, 1048575,       3,  1,  8},
      '{1,     0,  30000, 1,       3, 1048575,  2, 16}
   };

   ad_envelope_with_loop_and_vca_unit i_dut (.*);

   envl_checker i_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .fail_count, .pending
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result back-pressure: mostly ready, short stalls, now and then a long one
   always @(negedge clock) begin
      int r;
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (steady) begin
         rsp_tready <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 70) rsp_tready <= 1'b1;
         else begin
            rsp_tready <= 1'b0;
            stall_left = (r < 96) ? $urandom_range(0, 3) : $urandom_range(20, 70);
         end
      end
   end

   // watchdog on cycles without any accepted transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic int pick_offset();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 80) - 40;
      if (r < 85) return $urandom_range(0, 2097150) - 1048575;
      return (r < 92) ? 1048575 : -1048575;
   endfunction

   function automatic logic [103:0] pack_req(int ch, int trig, int aoff, int doff, int audio,
                                             int sel, int idx, int val);
      return {17'(val), 10'(idx), 1'(sel), 15'(audio), 21'(doff), 21'(aoff),
              15'(trig), 4'(ch)};
   endfunction

   task automatic send_req(logic kind, logic [103:0] d);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_tick(int ch, int trig, int aoff, int doff, int audio);
      send_req(OP_TICK, pack_req(ch, trig, aoff, doff, audio, $urandom_range(0, 1),
                                 $urandom_range(0, 1023), $urandom_range(0, 131071)));
   endtask

   task automatic send_table(int sel, int idx, int val);
      send_req(OP_TABLE, pack_req($urandom_range(0, 15), $urandom_range(0, 24000) - 12000,
                                  pick_offset(), pick_offset(),
                                  $urandom_range(0, 24000) - 12000, sel, idx, val));
   endtask

   task automatic write_reg(logic [2:0] idx, int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_config(int k);
      write_reg(REG_LOOP_MODE,     cfg_sets[k][0]);
      write_reg(REG_CURVE_SHAPE,   cfg_sets[k][1]);
      write_reg(REG_OUTPUT_LEVEL,  cfg_sets[k][2]);
      write_reg(REG_LEVEL_TO_ENV,  cfg_sets[k][3]);
      write_reg(REG_ATTACK_TICKS,  cfg_sets[k][4]);
      write_reg(REG_DECAY_TICKS,   cfg_sets[k][5]);
      write_reg(REG_SHORTEST,      cfg_sets[k][6]);
      write_reg(REG_CHANNEL_COUNT, cfg_sets[k][7]);
   endtask

   // hold requests until every result is in and the block has gone quiet
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   function automatic int pick_curve_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 0;
      if (r < 20) return 65536;
      if (r < 23) return $urandom_range(65537, 131071);
      return $urandom_range(0, 65536);
   endfunction

   // one random request under a given channel count
   task automatic random_req(int count);
      int eff, ch, trig, r;
      eff = (count == 0) ? 1 : (count > CHANNELS) ? CHANNELS : count;
      if ($urandom_range(0, 99) < 5) begin
         send_table($urandom_range(0, 1), $urandom_range(0, 1023), pick_curve_value());
         return;
      end
      ch = ($urandom_range(0, 99) < 85) ? $urandom_range(0, eff - 1) : $urandom_range(0, 15);
      if ($urandom_range(0, 2) == 0) trig_high[ch] = !trig_high[ch];
      r = $urandom_range(0, 99);
      if (trig_high[ch]) trig = (r < 10) ? 1000 : $urandom_range(1000, 12000);
      else trig = (r < 10) ? 999 : $urandom_range(0, 12999) - 12000;
      send_tick(ch, trig, pick_offset(), pick_offset(), $urandom_range(0, 24000) - 12000);
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      steady      = 1'b0;
      stall_left  = 0;
      idle_cycles = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill both curve tables so no unwritten entry is ever read
      for (int t = 0; t < 2 * CURVE_DEPTH; t++)
         send_table(t / CURVE_DEPTH, t % CURVE_DEPTH, pick_curve_value());

      // field extremes under the reset settings
      send_tick(0, 12000, 1048575, -1048575, 12000);
      send_tick(0, -12000, -1048575, 1048575, -12000);
      send_tick(15, 12000, 0, 0, -12000);
      send_tick(0, 999, 0, 0, 0);
      send_tick(0, 1000, 0, 0, 12000);
      send_tick(0, -1, 0, 0, -1);
      send_table(1, 1023, 131071);
      send_table(0, 0, 65536);
      drain();

      // zero slope: retrigger while the envelope sits at full scale in decay
      write_reg(REG_CURVE_SHAPE, 65536);
      write_reg(REG_ATTACK_TICKS, 1);
      write_reg(REG_SHORTEST, 1);
      write_reg(REG_DECAY_TICKS, 1048575);
      send_table(0, 1022, 65536);
      send_tick(0, 5000, 0, 0, 8000);
      send_tick(0, 0, 0, 0, 8000);
      send_tick(0, 5000, 0, 0, -8000);
      send_tick(0, 0, 0, 0, 8000);
      drain();

      // random phases, one per register setting
      for (int k = 0; k < 8; k++) begin
         apply_config(k);
         for (int n = 0; n < PHASE_REQS; n++) begin
            steady = (n < 30);
            random_req(cfg_sets[k][7]);
         end
         steady = 1'b0;
         drain();
      end

      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/envl_pkg.sv
rtl/envl_front.sv
rtl/envl_back.sv
rtl/ad_envelope_with_loop_and_vca_unit.sv
tb/envl_checker.sv
tb/tb_top.sv
